### hw/rtl/vdu_pkg.sv
package vdu_pkg;

    localparam int FIELD_W     = 16;
    localparam int RAW_W       = 32;
    localparam int ACC_W       = 42;
    localparam int OUT_W       = 26;
    localparam int ROOT_W      = 21;
    localparam int REM_W       = 23;
    localparam int SQRT_STEPS  = 21;
    localparam int STEP_W      = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    typedef enum logic [1:0] {
        MODE_EUCLID    = 2'd0,
        MODE_MANHATTAN = 2'd1,
        MODE_CHEBYSHEV = 2'd2,
        MODE_RESERVED  = 2'd3
    } metric_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ROOT,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] x_element;
        logic signed [FIELD_W-1:0] y_element;
        logic                      last_element;
    } elem_t;

    typedef struct packed {
        logic [OUT_W-1:0] distance_value;
        logic             overflow_flag;
    } result_t;

    typedef struct packed {
        logic [1:0] metric_mode;
    } cfg_t;

    // one finished vector, handed from the accumulator to the result stage
    typedef struct packed {
        logic [ACC_W-1:0] acc;
        metric_t          mode;
        logic             sat;
    } job_t;

endpackage

### hw/rtl/vdu_stream_if.sv
interface vdu_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/vdu_front.sv
module vdu_front #(
    parameter int MAX_LEN    = 1024,
    parameter int ELEM_WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  vdu_pkg::metric_t mode,
    vdu_stream_if.sink       elem,
    vdu_stream_if.source     job
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    logic [CNT_W-1:0]          count_reg;
    logic                      sat_reg;
    logic                      a_valid_reg;
    logic                      a_last_reg;
    logic                      a_en_reg;
    logic                      a_sat_reg;
    vdu_pkg::metric_t          a_mode_reg;
    logic [vdu_pkg::ACC_W-1:0] a_term_reg;
    logic [vdu_pkg::ACC_W-1:0] acc_reg;

    logic [vdu_pkg::RAW_W-1:0]  x_raw;
    logic [vdu_pkg::RAW_W-1:0]  y_raw;
    logic signed [ELEM_WIDTH:0] x_se;
    logic signed [ELEM_WIDTH:0] y_se;
    logic signed [ELEM_WIDTH:0] diff;
    logic [ELEM_WIDTH-1:0]      mag;
    logic [vdu_pkg::ACC_W-1:0]  mag_x;
    logic [vdu_pkg::ROOT_W-1:0] mag_lo;
    logic                       mag_big;
    logic [vdu_pkg::ACC_W-1:0]  sq;
    logic [vdu_pkg::ACC_W-1:0]  term;
    logic                       cnt_open;
    logic                       accept;
    logic                       a_consume;
    logic [vdu_pkg::ACC_W:0]    sum;
    logic [vdu_pkg::ACC_W-1:0]  sum_sat;
    logic [vdu_pkg::ACC_W-1:0]  acc_upd;

    // element = low ELEM_WIDTH bits of the field, two's complement
    assign x_raw = {{(vdu_pkg::RAW_W - vdu_pkg::FIELD_W){1'b0}}, elem.payload.x_element};
    assign y_raw = {{(vdu_pkg::RAW_W - vdu_pkg::FIELD_W){1'b0}}, elem.payload.y_element};
    assign x_se  = signed'({x_raw[ELEM_WIDTH-1], x_raw[ELEM_WIDTH-1:0]});
    assign y_se  = signed'({y_raw[ELEM_WIDTH-1], y_raw[ELEM_WIDTH-1:0]});
    assign diff  = x_se - y_se;
    assign mag   = diff[ELEM_WIDTH] ? ELEM_WIDTH'(-diff) : diff[ELEM_WIDTH-1:0];

    assign mag_x   = vdu_pkg::ACC_W'(mag);
    assign mag_big = |mag_x[vdu_pkg::ACC_W-1:vdu_pkg::ROOT_W];
    assign mag_lo  = mag_x[vdu_pkg::ROOT_W-1:0];
    assign sq      = vdu_pkg::ACC_W'(mag_lo) * vdu_pkg::ACC_W'(mag_lo);

    always_comb
    begin
        case (mode)
            vdu_pkg::MODE_EUCLID: term = mag_big ? vdu_pkg::ACC_MAX : sq;
            default:              term = mag_x;
        endcase
    end

    assign cnt_open  = (count_reg != CNT_W'(MAX_LEN));
    assign a_consume = a_valid_reg && (!a_last_reg || job.ready);
    assign elem.ready = !a_valid_reg || a_consume;
    assign accept    = elem.valid && elem.ready;

    assign sum     = {1'b0, acc_reg} + {1'b0, a_term_reg};
    assign sum_sat = sum[vdu_pkg::ACC_W] ? vdu_pkg::ACC_MAX : sum[vdu_pkg::ACC_W-1:0];

    always_comb
    begin
        acc_upd = acc_reg;
        if (a_en_reg)
        begin
            case (a_mode_reg)
                vdu_pkg::MODE_EUCLID,
                vdu_pkg::MODE_MANHATTAN: acc_upd = sum_sat;
                vdu_pkg::MODE_CHEBYSHEV: acc_upd = (a_term_reg > acc_reg) ? a_term_reg : acc_reg;
                default:                 acc_upd = acc_reg;
            endcase
        end
    end

    assign job.valid       = a_valid_reg && a_last_reg;
    assign job.payload.acc  = acc_upd;
    assign job.payload.mode = a_mode_reg;
    assign job.payload.sat  = a_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            sat_reg     <= 1'b0;
            a_valid_reg <= 1'b0;
            a_last_reg  <= 1'b0;
            a_en_reg    <= 1'b0;
            a_sat_reg   <= 1'b0;
            a_mode_reg  <= vdu_pkg::MODE_EUCLID;
            a_term_reg  <= '0;
            acc_reg     <= '0;
        end
        else
        begin
            if (elem.ready)
                a_valid_reg <= elem.valid;
            if (accept)
            begin
                a_last_reg <= elem.payload.last_element;
                a_en_reg   <= cnt_open;
                a_sat_reg  <= sat_reg || !cnt_open;
                a_mode_reg <= mode;
                a_term_reg <= term;
                if (elem.payload.last_element)
                begin
                    count_reg <= '0;
                    sat_reg   <= 1'b0;
                end
                else if (cnt_open)
                    count_reg <= count_reg + CNT_W'(1);
                else
                    sat_reg <= 1'b1;
            end
            if (a_consume)
                acc_reg <= a_last_reg ? '0 : acc_upd;
        end
    end

endmodule

### hw/rtl/vdu_queue.sv
module vdu_queue (
    input  logic         clk,
    input  logic         rst_n,
    vdu_stream_if.sink   push,
    vdu_stream_if.source pop
);

    localparam int QPW = (vdu_pkg::QUEUE_DEPTH > 1) ? $clog2(vdu_pkg::QUEUE_DEPTH) : 1;

    vdu_pkg::job_t  mem [vdu_pkg::QUEUE_DEPTH];
    logic [QPW-1:0] wr_ptr_reg;
    logic [QPW-1:0] rd_ptr_reg;
    logic [QPW:0]   fill_reg;
    logic           do_push;
    logic           do_pop;

    assign push.ready  = (fill_reg != (QPW+1)'(vdu_pkg::QUEUE_DEPTH));
    assign pop.valid   = (fill_reg != '0);
    assign pop.payload = mem[rd_ptr_reg];
    assign do_push     = push.valid && push.ready;
    assign do_pop      = pop.valid && pop.ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push.payload;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPW'(vdu_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + QPW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPW'(vdu_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + QPW'(1);
            case ({do_push, do_pop})
                2'b10:   fill_reg <= fill_reg + (QPW+1)'(1);
                2'b01:   fill_reg <= fill_reg - (QPW+1)'(1);
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

### hw/rtl/vdu_back.sv
module vdu_back (
    input  logic         clk,
    input  logic         rst_n,
    vdu_stream_if.sink   job,
    vdu_stream_if.source result
);

    vdu_pkg::back_state_t state_reg, state_next;

    logic [vdu_pkg::ACC_W-1:0]  rad_reg, rad_next;
    logic [vdu_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [vdu_pkg::ROOT_W-1:0] root_reg, root_next;
    logic [vdu_pkg::STEP_W-1:0] step_reg, step_next;
    logic                       out_valid_reg;
    vdu_pkg::result_t           out_reg;

    logic                       out_free;
    logic                       out_load;
    vdu_pkg::result_t           out_next;
    logic [vdu_pkg::REM_W-1:0]  rem_sh;
    logic [vdu_pkg::REM_W-1:0]  trial;
    logic [vdu_pkg::OUT_W-1:0]  direct_val;
    logic                       use_root;

    assign out_free       = !out_valid_reg || result.ready;
    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    // one result bit per cycle, two radicand bits shifted in each step
    assign rem_sh = {rem_reg[vdu_pkg::REM_W-3:0], rad_reg[vdu_pkg::ACC_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};

    assign use_root = !job.payload.sat && (job.payload.mode == vdu_pkg::MODE_EUCLID);

    always_comb
    begin
        case (job.payload.mode)
            vdu_pkg::MODE_MANHATTAN,
            vdu_pkg::MODE_CHEBYSHEV:
                direct_val = (|job.payload.acc[vdu_pkg::ACC_W-1:vdu_pkg::OUT_W]) ?
                             vdu_pkg::OUT_MAX : job.payload.acc[vdu_pkg::OUT_W-1:0];
            default:
                direct_val = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        step_next  = step_reg;
        job.ready  = 1'b0;
        out_load   = 1'b0;
        out_next   = out_reg;
        case (state_reg)
            vdu_pkg::BK_IDLE:
            begin
                if (job.valid && (use_root || out_free))
                begin
                    job.ready = 1'b1;
                    if (use_root)
                    begin
                        rad_next   = job.payload.acc;
                        rem_next   = '0;
                        root_next  = '0;
                        step_next  = '0;
                        state_next = vdu_pkg::BK_ROOT;
                    end
                    else
                    begin
                        out_load = 1'b1;
                        out_next.overflow_flag  = job.payload.sat;
                        out_next.distance_value = job.payload.sat ? vdu_pkg::OUT_MAX : direct_val;
                    end
                end
            end
            vdu_pkg::BK_ROOT:
            begin
                rad_next = {rad_reg[vdu_pkg::ACC_W-3:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[vdu_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[vdu_pkg::ROOT_W-2:0], 1'b0};
                end
                if (step_reg == vdu_pkg::STEP_W'(vdu_pkg::SQRT_STEPS - 1))
                    state_next = vdu_pkg::BK_EMIT;
                else
                    step_next = step_reg + vdu_pkg::STEP_W'(1);
            end
            vdu_pkg::BK_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    out_next.overflow_flag  = 1'b0;
                    out_next.distance_value = vdu_pkg::OUT_W'(root_reg);
                    state_next = vdu_pkg::BK_IDLE;
                end
            end
            default:
                state_next = vdu_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vdu_pkg::BK_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        out_reg  <= out_next;
    end

endmodule

### hw/rtl/vector_distance_unit_top.sv
// Streaming vector distance, signed Q8.8 elements in, unsigned Q18.8 distance out.
// Channels (valid/ready, transfer when both high at a rising edge):
//   elem   - one element pair per transfer, last_element closes the vector.
//   result - one transfer per vector: distance_value and overflow_flag.
//   cfg    - metric_mode (0 Euclidean, 1 Manhattan, 2 Chebyshev); change it
//            only between vectors, with no result outstanding.
// Throughput: one element pair per cycle while elem is not stalled. The
// accumulator folds each pair in from the input register; a closed vector
// moves into a two-entry queue in front of the result stage, so the next
// vector streams in while the previous one is finished.
// Manhattan, Chebyshev and overflowed vectors go from the queue straight to
// the result register; Euclidean vectors first pass through the square root,
// which produces one result bit per cycle.
// A new vector whose result cannot be queued stalls elem until a queue slot
// frees; a stalled result register holds its value and backs up the queue.
// Reset clears the mode to Euclidean, the accumulator, count and queue.
module vector_distance_unit_top #(
    parameter int MAX_LEN    = 1024,
    parameter int ELEM_WIDTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    vdu_stream_if.sink   elem,
    vdu_stream_if.source result,
    vdu_stream_if.sink   cfg
);

    vdu_pkg::metric_t mode_reg;

    vdu_stream_if #(.payload_t(vdu_pkg::job_t)) job_push ();
    vdu_stream_if #(.payload_t(vdu_pkg::job_t)) job_pop ();

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= vdu_pkg::MODE_EUCLID;
        else if (cfg.valid)
            mode_reg <= vdu_pkg::metric_t'(cfg.payload.metric_mode);
    end

    vdu_front #(
        .MAX_LEN    (MAX_LEN),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .mode  (mode_reg),
        .elem  (elem),
        .job   (job_push)
    );

    vdu_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .pop   (job_pop)
    );

    vdu_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .job    (job_pop),
        .result (result)
    );

    // input stalls only when a closed vector cannot enter the queue
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !elem.ready |-> (job_push.valid && !job_push.ready))
        else $error("element input stalled without a blocked vector");

    a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.payload.overflow_flag) |->
        (result.payload.distance_value == vdu_pkg::OUT_MAX))
        else $error("overflowed vector without saturated distance");

    // a vector at the queue head that is not taken stays valid; nothing is dropped
    a_pop_order: assert property (@(posedge clk) disable iff (!rst_n)
        (job_pop.valid && !job_pop.ready) |=> job_pop.valid)
        else $error("queued vector lost");

endmodule

### test/vdu_distance_check.sv
module vdu_distance_check
    import vdu_pkg::*;
#(
    parameter int MAX_LEN = 1024
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    elem_valid,
    input  logic    elem_ready,
    input  elem_t   elem_data,
    input  logic    result_valid,
    input  logic    result_ready,
    input  result_t result_data,
    input  logic    cfg_valid,
    input  logic    cfg_ready,
    input  cfg_t    cfg_data,
    output int      fail_count,
    output int      pending
);

    metric_t          mode_q;
    logic [ACC_W-1:0] acc_q;
    int               count_q;
    logic             sat_q;
    result_t          expected_distances[$];
    result_t          want;
    int               reported;

    function automatic logic [OUT_W-1:0] floor_root(input logic [ACC_W-1:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= {22'd0, v})
                root = trial;
        end
        return OUT_W'(root);
    endfunction

    function automatic logic [ACC_W-1:0] add_clamped(input logic [ACC_W-1:0] a,
                                                     input logic [63:0] b);
        logic [63:0] s;
        s = {22'd0, a} + b;
        return (s > {22'd0, ACC_MAX}) ? ACC_MAX : s[ACC_W-1:0];
    endfunction

    // fold one element pair into the running distance; close the vector on last
    task automatic fold_element(input elem_t e);
        int          diff;
        logic [63:0] mag;
        logic [63:0] dist_val;
        result_t     r;
        diff = int'($signed(e.x_element)) - int'($signed(e.y_element));
        mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
        if (count_q >= MAX_LEN)
            sat_q = 1'b1;
        else
        begin
            count_q++;
            case (mode_q)
                MODE_EUCLID:
                    acc_q = add_clamped(acc_q, (mag >= (64'd1 << ROOT_W)) ?
                                               {22'd0, ACC_MAX} : mag * mag);
                MODE_MANHATTAN:
                    acc_q = add_clamped(acc_q, mag);
                MODE_CHEBYSHEV:
                    if (mag > {22'd0, acc_q})
                        acc_q = mag[ACC_W-1:0];
                default: ;
            endcase
        end
        if (e.last_element)
        begin
            if (sat_q)
            begin
                r.distance_value = OUT_MAX;
                r.overflow_flag  = 1'b1;
            end
            else
            begin
                case (mode_q)
                    MODE_EUCLID:   dist_val = 64'(floor_root(acc_q));
                    MODE_RESERVED: dist_val = '0;
                    default:       dist_val = {22'd0, acc_q};
                endcase
                if (dist_val > 64'(OUT_MAX))
                    dist_val = 64'(OUT_MAX);
                r.distance_value = dist_val[OUT_W-1:0];
                r.overflow_flag  = 1'b0;
            end
            expected_distances.push_back(r);
            acc_q   = '0;
            count_q = 0;
            sat_q   = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_q     = MODE_EUCLID;
            acc_q      = '0;
            count_q    = 0;
            sat_q      = 1'b0;
            fail_count = 0;
            reported   = 0;
            pending    = 0;
            expected_distances.delete();
        end
        else
        begin
            // an element in the same transfer cycle still sees the old mode
            if (elem_valid && elem_ready)
                fold_element(elem_data);
            if (cfg_valid && cfg_ready)
                mode_q = metric_t'(cfg_data.metric_mode);
            if (result_valid && result_ready)
            begin
                if (expected_distances.size() == 0)
                begin
                    fail_count++;
                    if (reported < 10)
                        $display("unexpected result transfer at %0t: distance %0d overflow %0b",
                                 $time, result_data.distance_value,
                                 result_data.overflow_flag);
                    reported++;
                end
                else
                begin
                    want = expected_distances.pop_front();
                    if (result_data.distance_value !== want.distance_value ||
                        result_data.overflow_flag !== want.overflow_flag)
                    begin
                        fail_count++;
                        if (reported < 10)
                            $display("result mismatch at %0t: expected %0d/%0b, got %0d/%0b",
                                     $time, want.distance_value, want.overflow_flag,
                                     result_data.distance_value,
                                     result_data.overflow_flag);
                        reported++;
                    end
                end
            end
            pending = expected_distances.size();
        end
    end

endmodule

### test/tb.sv
module tb;
    import vdu_pkg::*;

    localparam int LIMIT = 1000000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   cycles = 0;
    int   fail_count;
    int   pending;
    int   burst_left = 0;
    bit   steady = 1'b0;

    vdu_stream_if #(.payload_t(elem_t))   elem_if ();
    vdu_stream_if #(.payload_t(result_t)) result_if ();
    vdu_stream_if #(.payload_t(cfg_t))    cfg_if ();

    vector_distance_unit_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .elem   (elem_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    vdu_distance_check #(.MAX_LEN(1024)) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .elem_valid   (elem_if.valid),
        .elem_ready   (elem_if.ready),
        .elem_data    (elem_if.payload),
        .result_valid (result_if.valid),
        .result_ready (result_if.ready),
        .result_data  (result_if.payload),
        .cfg_valid    (cfg_if.valid),
        .cfg_ready    (cfg_if.ready),
        .cfg_data     (cfg_if.payload),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("vector_distance_unit_top verification failed");
            $finish;
        end
    end

    // result side back-pressure, density changes every span
    initial
    begin
        int stall_pct;
        int span;
        stall_pct = 0;
        span      = 0;
        result_if.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (span == 0)
            begin
                span = $urandom_range(16, 128);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            span--;
            result_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic elem_t pair(input logic [15:0] x, input logic [15:0] y,
                                   input logic last);
        elem_t e;
        e.x_element    = x;
        e.y_element    = y;
        e.last_element = last;
        return e;
    endfunction

    function automatic elem_t random_pair(input logic last, input bit extreme);
        elem_t e;
        e.last_element = last;
        if (extreme)
        begin
            e.x_element = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            e.y_element = ~e.x_element;
        end
        else
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    e.x_element = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                    e.y_element = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
                end
                1, 2:
                begin
                    e.x_element = 16'(int'($urandom_range(0, 600)) - 300);
                    e.y_element = 16'(int'($urandom_range(0, 600)) - 300);
                end
                3:
                begin
                    e.x_element = 16'($urandom);
                    e.y_element = e.x_element;
                end
                default:
                begin
                    e.x_element = 16'($urandom);
                    e.y_element = 16'($urandom);
                end
            endcase
        end
        return e;
    endfunction

    // bursty sender: random gap before each burst unless the phase is steady
    task automatic send_pair(input elem_t e);
        int gap;
        if (burst_left == 0)
        begin
            gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                elem_if.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        elem_if.valid   <= 1'b1;
        elem_if.payload <= e;
        @(posedge clk);
        while (!elem_if.ready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic send_vector(input int len, input bit extreme);
        for (int i = 0; i < len; i++)
            send_pair(random_pair(i == len - 1, extreme));
    endtask

    // drop valid, wait for every result, then idle before the next phase
    task automatic settle();
        @(negedge clk);
        elem_if.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic write_metric(input metric_t m);
        cfg_t c;
        c.metric_mode = m;
        @(negedge clk);
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= c;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    initial
    begin
        int sent;
        int len;
        elem_if.valid   <= 1'b0;
        elem_if.payload <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.payload  <= '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Euclidean from reset: widest difference both ways, zero, bit patterns
        send_pair(pair(16'h7FFF, 16'h8000, 1'b1));
        send_pair(pair(16'h8000, 16'h7FFF, 1'b0));
        send_pair(pair(16'h0000, 16'h0000, 1'b0));
        send_pair(pair(16'h0001, 16'h0000, 1'b1));
        send_pair(pair(16'hFFFF, 16'hFFFF, 1'b1));
        send_pair(pair(16'h5555, 16'hAAAA, 1'b1));

        settle();
        write_metric(MODE_MANHATTAN);
        send_pair(pair(16'h7FFF, 16'h8000, 1'b0));
        send_pair(pair(16'h8000, 16'h7FFF, 1'b1));
        // mode switch inside a vector: Manhattan part, then Euclidean close
        send_pair(pair(16'h0100, 16'h0000, 1'b0));
        send_pair(pair(16'hFE00, 16'h0000, 1'b0));
        settle();
        write_metric(MODE_EUCLID);
        send_pair(pair(16'h0003, 16'h0000, 1'b1));

        settle();
        write_metric(MODE_CHEBYSHEV);
        send_pair(pair(16'h0064, 16'hFF9C, 1'b0));
        send_pair(pair(16'h8000, 16'h7FFF, 1'b0));
        send_pair(pair(16'h0003, 16'h0004, 1'b1));

        settle();
        write_metric(MODE_RESERVED);
        send_pair(pair(16'h03E8, 16'h0005, 1'b0));
        send_pair(pair(16'hFFF9, 16'h0009, 1'b1));

        for (int ph = 0; ph < 12; ph++)
        begin
            settle();
            write_metric(ph < 4 ? metric_t'(ph) : metric_t'($urandom_range(0, 3)));
            steady = ($urandom_range(0, 3) == 0);
            // one element past the length limit, must saturate
            if (ph == 8)
                send_vector(1025, 1'b0);
            sent = 0;
            while (sent < 35)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64)
                                                  : $urandom_range(1, 8);
                send_vector(len, $urandom_range(0, 19) == 0);
                sent += len;
            end
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("vector_distance_unit_top verification clean");
        else
            $display("vector_distance_unit_top verification failed");
        $finish;
    end

endmodule

### sim.f
hw/rtl/vdu_pkg.sv
hw/rtl/vdu_stream_if.sv
hw/rtl/vdu_front.sv
hw/rtl/vdu_queue.sv
hw/rtl/vdu_back.sv
hw/rtl/vector_distance_unit_top.sv
test/vdu_distance_check.sv
test/tb.sv
